### hdl/pasm_pkg.sv
// Package for the polynomial add / subtract / multiply core.
// Holds sizes, operation and mode codes, sequencer states, control structs
// and saturation helpers. No dependencies.
package pasm_pkg;

  localparam int COEF_W   = 16;
  localparam int EXP_W    = 5;
  localparam int NUM_EXP  = 32;
  localparam int PEXP_W   = 6;
  localparam int NUM_PEXP = 2 * NUM_EXP - 1;
  localparam int PROD_W   = 2 * COEF_W;
  localparam int OUT_W    = 38;

  localparam logic [EXP_W-1:0]  EXP_TOP  = EXP_W'(NUM_EXP - 1);
  localparam logic [PEXP_W-1:0] PEXP_TOP = PEXP_W'(NUM_PEXP - 1);

  // Request operation codes
  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_RUN    = 2'd2,
    OP_CLEAR  = 2'd3
  } oper_t;

  // Run mode register codes
  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_SUB  = 2'd1,
    MODE_MUL  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  // Sequencer states
  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_ADD_SCAN  = 7'b0000010,
    S_MUL_PAIR  = 7'b0000100,
    S_MUL_ACC   = 7'b0001000,
    S_PROD_SCAN = 7'b0010000,
    S_PROD_OUT  = 7'b0100000,
    S_EMPTY     = 7'b1000000
  } state_t;

  // Term store load / clear controls
  typedef struct packed {
    logic                     load_a;
    logic                     load_b;
    logic                     clear;
    logic signed [COEF_W-1:0] coef;
  } ld_ctrl_t;

  // Multiply-accumulate unit controls
  typedef struct packed {
    logic              clear;
    logic              mul;
    logic              acc;
    logic              rd;
    logic [PEXP_W-1:0] addr;
  } mac_ctrl_t;

  // Saturate a one-bit-grown sum to the coefficient range
  function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [COEF_W:0] v);
    logic signed [COEF_W-1:0] r;
    if (v[COEF_W] != v[COEF_W-1]) begin
      r = v[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      r = v[COEF_W-1:0];
    end
    return r;
  endfunction

  // Saturate a one-bit-grown sum to the result range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [OUT_W:0] v);
    logic signed [OUT_W-1:0] r;
    if (v[OUT_W] != v[OUT_W-1]) begin
      r = v[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/polynomial_add_sub_multiply_core.sv
// Top level of the polynomial add / subtract / multiply core: sequencer,
// mode register and result output register. Depends on pasm_pkg,
// pasm_store and pasm_mac.
// Load and clear requests complete while idle. An add or subtract run walks
// exponents from 31 down to the lowest present one. A multiply run visits
// every B entry of a present A row, with a multiply and an accumulate
// state per present pair, and each absent A row once, then scans product
// exponents from 62 down, reading and emitting each present one; the single
// multiplier and accumulator memory port set this. Output stalls hold it.
// Reset clears mode, presence marks, sequencer and output valid; no clearing pass.
module polynomial_add_sub_multiply_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         operation,
  input  logic signed [pasm_pkg::COEF_W-1:0] coefficient,
  input  logic [pasm_pkg::EXP_W-1:0]         exponent,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pasm_pkg::OUT_W-1:0]  term_coefficient,
  output logic [pasm_pkg::PEXP_W-1:0]        term_exponent,
  output logic                               last_term,
  output logic                               empty_result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         op_mode
);
  import pasm_pkg::*;

  state_t                   state, state_next;
  mode_t                    mode;
  logic [EXP_W-1:0]         i_cnt, i_next;
  logic [EXP_W-1:0]         j_cnt, j_next;
  logic [PEXP_W-1:0]        k_cnt, k_next;
  ld_ctrl_t                 ld;
  mac_ctrl_t                mctl;
  logic [EXP_W-1:0]         idx_a, idx_b;
  logic signed [COEF_W-1:0] a_coef, b_coef;
  logic [NUM_EXP-1:0]       a_present, b_present, present_u;
  logic [NUM_PEXP-1:0]      prod_present;
  logic signed [OUT_W-1:0]  prod_rdata;
  logic signed [COEF_W:0]   addsub;
  logic                     add_last, prod_last, row_end, advance;
  logic                     in_accept, out_free, load_out;
  logic signed [OUT_W-1:0]  nxt_coef;
  logic [PEXP_W-1:0]        nxt_exp;
  logic                     nxt_last, nxt_empty;

  pasm_store u_store (
    .clk       (clk),
    .rst       (rst),
    .ld        (ld),
    .idx_a     (idx_a),
    .idx_b     (idx_b),
    .a_coef    (a_coef),
    .b_coef    (b_coef),
    .a_present (a_present),
    .b_present (b_present)
  );

  pasm_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (mctl),
    .a_coef       (a_coef),
    .b_coef       (b_coef),
    .rdata        (prod_rdata),
    .prod_present (prod_present)
  );

  // Handshakes
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = (state == S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // Combined terms and end-of-run detection
  assign present_u = a_present | b_present;
  assign addsub    = (mode == MODE_SUB) ? (COEF_W+1)'(a_coef) - (COEF_W+1)'(b_coef)
                                        : (COEF_W+1)'(a_coef) + (COEF_W+1)'(b_coef);
  assign add_last  = (present_u & ~({NUM_EXP{1'b1}} << i_cnt)) == '0;
  assign prod_last = (prod_present & ~({NUM_PEXP{1'b1}} << k_cnt)) == '0;
  assign row_end   = (j_cnt == EXP_TOP) || !a_present[i_cnt];

  // Store addresses: request exponent while idle, counters while running
  always_comb begin
    idx_a = (state == S_IDLE) ? exponent : i_cnt;
    if (state == S_IDLE) begin
      idx_b = exponent;
    end else if (state == S_ADD_SCAN) begin
      idx_b = i_cnt;
    end else begin
      idx_b = j_cnt;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    i_next     = i_cnt;
    j_next     = j_cnt;
    k_next     = k_cnt;
    ld         = '0;
    ld.coef    = coefficient;
    mctl       = '0;
    mctl.addr  = (state == S_MUL_PAIR) ? PEXP_W'(i_cnt) + PEXP_W'(j_cnt) : k_cnt;
    load_out   = 1'b0;
    nxt_coef   = '0;
    nxt_exp    = '0;
    nxt_last   = 1'b0;
    nxt_empty  = 1'b0;
    advance    = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          unique case (oper_t'(operation))
            OP_LOAD_A: ld.load_a = 1'b1;
            OP_LOAD_B: ld.load_b = 1'b1;
            OP_CLEAR: begin
              ld.clear   = 1'b1;
              mctl.clear = 1'b1;
            end
            OP_RUN: begin
              unique case (mode) inside
                MODE_ADD, MODE_SUB: begin
                  i_next     = EXP_TOP;
                  state_next = (present_u == '0) ? S_EMPTY : S_ADD_SCAN;
                end
                MODE_MUL: begin
                  mctl.clear = 1'b1;
                  i_next     = '0;
                  j_next     = '0;
                  state_next = S_MUL_PAIR;
                end
                default: state_next = S_EMPTY;
              endcase
            end
            default: ;
          endcase
        end
      end

      // Walk exponents downward, emit each present one
      S_ADD_SCAN: begin
        if (present_u[i_cnt]) begin
          if (out_free) begin
            load_out = 1'b1;
            nxt_coef = OUT_W'(addsub);
            nxt_exp  = PEXP_W'(i_cnt);
            nxt_last = add_last;
            if (add_last) begin
              state_next = S_IDLE;
            end else begin
              i_next = i_cnt - 1'b1;
            end
          end
        end else begin
          i_next = i_cnt - 1'b1;
        end
      end

      // Issue a multiply for a present pair, or skip ahead
      S_MUL_PAIR: begin
        if (a_present[i_cnt] && b_present[j_cnt]) begin
          mctl.mul   = 1'b1;
          state_next = S_MUL_ACC;
        end else begin
          advance = 1'b1;
        end
      end

      S_MUL_ACC: begin
        mctl.acc = 1'b1;
        advance  = 1'b1;
      end

      // Walk product exponents downward, read each present one
      S_PROD_SCAN: begin
        if (prod_present == '0) begin
          state_next = S_EMPTY;
        end else if (prod_present[k_cnt]) begin
          mctl.rd    = 1'b1;
          state_next = S_PROD_OUT;
        end else begin
          k_next = k_cnt - 1'b1;
        end
      end

      S_PROD_OUT: begin
        if (out_free) begin
          load_out = 1'b1;
          nxt_coef = prod_rdata;
          nxt_exp  = k_cnt;
          nxt_last = prod_last;
          if (prod_last) begin
            state_next = S_IDLE;
          end else begin
            k_next     = k_cnt - 1'b1;
            state_next = S_PROD_SCAN;
          end
        end
      end

      S_EMPTY: begin
        if (out_free) begin
          load_out   = 1'b1;
          nxt_last   = 1'b1;
          nxt_empty  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // Step to the next term pair; after the last one start emitting
    if (advance) begin
      if (row_end) begin
        j_next = '0;
        if (i_cnt == EXP_TOP) begin
          k_next     = PEXP_TOP;
          state_next = S_PROD_SCAN;
        end else begin
          i_next     = i_cnt + 1'b1;
          state_next = S_MUL_PAIR;
        end
      end else begin
        j_next     = j_cnt + 1'b1;
        state_next = S_MUL_PAIR;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= MODE_ADD;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) mode <= mode_t'(op_mode);
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    i_cnt <= i_next;
    j_cnt <= j_next;
    k_cnt <= k_next;
  end

  // Output register: hold while stalled, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      term_coefficient <= nxt_coef;
      term_exponent    <= nxt_exp;
      last_term        <= nxt_last;
      empty_result     <= nxt_empty;
    end
  end

  // Add scan only runs when some term exists
  a_add_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD_SCAN) |-> (present_u != '0))
    else $error("add scan entered with no terms");

  // Product emit only reads present exponents
  a_prod_present: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROD_OUT) |-> prod_present[k_cnt])
    else $error("emitting absent product exponent");

  // A new result only comes from a running sequencer
  a_out_from_run: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (state != S_IDLE))
    else $error("result loaded while idle");

endmodule

### hdl/pasm_store.sv
// Term stores for polynomials A and B: per-exponent coefficients with
// presence marks, saturating accumulate on load. Depends on pasm_pkg.
module pasm_store (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pasm_pkg::ld_ctrl_t                     ld,
  input  logic [pasm_pkg::EXP_W-1:0]             idx_a,
  input  logic [pasm_pkg::EXP_W-1:0]             idx_b,
  output logic signed [pasm_pkg::COEF_W-1:0]     a_coef,
  output logic signed [pasm_pkg::COEF_W-1:0]     b_coef,
  output logic [pasm_pkg::NUM_EXP-1:0]           a_present,
  output logic [pasm_pkg::NUM_EXP-1:0]           b_present
);
  import pasm_pkg::*;

  logic signed [COEF_W-1:0] a_mem [NUM_EXP];
  logic signed [COEF_W-1:0] b_mem [NUM_EXP];
  logic signed [COEF_W:0]   a_sum;
  logic signed [COEF_W:0]   b_sum;

  // Read one entry per store; an absent exponent reads as zero
  assign a_coef = a_present[idx_a] ? a_mem[idx_a] : '0;
  assign b_coef = b_present[idx_b] ? b_mem[idx_b] : '0;

  // Accumulate the loaded term onto the stored coefficient
  assign a_sum = (COEF_W+1)'(a_coef) + (COEF_W+1)'(ld.coef);
  assign b_sum = (COEF_W+1)'(b_coef) + (COEF_W+1)'(ld.coef);

  // Presence marks
  always_ff @(posedge clk) begin
    if (rst || ld.clear) begin
      a_present <= '0;
      b_present <= '0;
    end else begin
      if (ld.load_a) a_present[idx_a] <= 1'b1;
      if (ld.load_b) b_present[idx_b] <= 1'b1;
    end
  end

  // Coefficient storage
  always_ff @(posedge clk) begin
    if (ld.load_a) a_mem[idx_a] <= sat_coef(a_sum);
    if (ld.load_b) b_mem[idx_b] <= sat_coef(b_sum);
  end

endmodule

### hdl/pasm_mac.sv
// Shared multiply-accumulate unit: one multiplier, product accumulator
// memory with presence marks and saturating add. Depends on pasm_pkg.
module pasm_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pasm_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [pasm_pkg::COEF_W-1:0]   a_coef,
  input  logic signed [pasm_pkg::COEF_W-1:0]   b_coef,
  output logic signed [pasm_pkg::OUT_W-1:0]    rdata,
  output logic [pasm_pkg::NUM_PEXP-1:0]        prod_present
);
  import pasm_pkg::*;

  logic signed [OUT_W-1:0]  acc_mem [NUM_PEXP];
  logic signed [OUT_W-1:0]  rd_q;
  logic [PEXP_W-1:0]        addr_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [OUT_W:0]    acc_sum;

  // Entry not yet written in this run reads as zero
  assign rdata   = prod_present[addr_q] ? rd_q : '0;
  assign acc_sum = (OUT_W+1)'(rdata) + (OUT_W+1)'(prod);

  // Register the product and read the accumulator entry
  always_ff @(posedge clk) begin
    if (ctrl.mul) prod <= a_coef * b_coef;
    if (ctrl.mul || ctrl.rd) begin
      rd_q   <= acc_mem[ctrl.addr];
      addr_q <= ctrl.addr;
    end
    if (ctrl.acc) acc_mem[addr_q] <= sat_out(acc_sum);
  end

  // Presence marks per product exponent
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      prod_present <= '0;
    end else if (ctrl.acc) begin
      prod_present[addr_q] <= 1'b1;
    end
  end

  // Accumulate only follows a multiply of the same pair
  a_acc_after_mul: assert property (@(posedge clk) disable iff (rst)
    ctrl.acc |-> $past(ctrl.mul))
    else $error("accumulate without preceding multiply");

  // Never multiply or read in the same cycle as a write back
  a_mul_acc_excl: assert property (@(posedge clk) disable iff (rst)
    ctrl.acc |-> !ctrl.mul && !ctrl.rd)
    else $error("accumulate overlaps a read");

endmodule
